### hw/rtl/table_seeded_float_rsqrt_unit_defines.svh
// Assertion macros shared by the table-seeded rsqrt unit.
`ifndef TABLE_SEEDED_FLOAT_RSQRT_UNIT_DEFINES_SVH
`define TABLE_SEEDED_FLOAT_RSQRT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TRSQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TRSQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/trsq_pkg.sv
// Package: constants, types and seed table builder for the rsqrt unit.
`default_nettype none

package trsq_pkg;

   localparam int SEED_ENTRIES = 1024;
   localparam int SEED_ADDR_W  = $clog2(SEED_ENTRIES);
   localparam int SEED_LSB     = 14;

   localparam logic [31:0] SEED_EXP_BASE   = 32'h5f00_0000;
   localparam logic [31:0] SEED_EXP_MASK   = 32'hff80_0000;
   localparam logic [31:0] F32_THREE       = 32'h4040_0000;
   localparam logic [31:0] F32_HALF        = 32'h3f00_0000;
   localparam logic [31:0] F32_QNAN_BIT    = 32'h0040_0000;
   localparam logic [31:0] F32_DEFAULT_NAN = 32'hffc0_0000;
   localparam logic [31:0] F32_SIGN_BIT    = 32'h8000_0000;

   localparam int FMUL_STAGES = 3;
   localparam int FSUB_STAGES = 2;

   // Word carried alongside each operation through the pipe.
   typedef struct packed {
      logic        op;
      logic [31:0] x_bits;
      logic [31:0] y_bits;
   } side_type;

   typedef logic [7:0] seed_rom_type [SEED_ENTRIES];

   // One seed byte: rounded single 1/sqrt(f), f = n / 2^s, bits 22..15 rounded.
   function automatic logic [7:0] seed_entry(input int unsigned idx);
      logic [127:0] lim;
      logic [127:0] trial;
      logic [127:0] prod;
      logic [63:0]  q;
      logic [63:0]  sig;
      logic [31:0]  n;
      logic [31:0]  e;
      logic [31:0]  bits;
      int           s;
      n   = 32'(512 + (idx & 511));
      s   = ((idx & 512) != 0) ? 9 : 10;
      lim = 128'd1 << (s + 52);
      q   = 64'd0;
      // q = floor(sqrt(lim / n)), found bit by bit
      for (int b = 27; b >= 0; b--) begin
         trial = {64'd0, q | (64'd1 << b)};
         prod  = trial * trial * {96'd0, n};
         if (prod <= lim) begin
            q = trial[63:0];
         end
      end
      if (q >= (64'd1 << 26)) begin
         e   = 32'd127;
         sig = (q + 64'd4) >> 3;
      end else begin
         e   = 32'd126;
         sig = (q + 64'd2) >> 2;
      end
      if (sig >= (64'd1 << 24)) begin
         e   = e + 32'd1;
         sig = sig >> 1;
      end
      bits = (e << 23) | {9'd0, sig[22:0]};
      bits = (bits + 32'h2000) >> 15;
      return bits[7:0];
   endfunction

   function automatic seed_rom_type build_seed_rom();
      seed_rom_type rom;
      for (int i = 0; i < SEED_ENTRIES; i++) begin
         rom[i] = seed_entry(i);
      end
      rom[SEED_ENTRIES / 2] = 8'hff;
      return rom;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/table_seeded_float_rsqrt_unit.sv
// Top level: table-seeded single-precision rsqrt / sqrt with two Newton steps.
//
//   channel   ports                              handshake
//   -------   --------------------------------   ------------------------------
//   request   req_op, req_x_bits                 start high and busy low
//   response  rsp_result_bits                    rsp_strobe high for one cycle
//
// One word enters per cycle while busy is low. Its path holds a chain of eleven IEEE
// operations and the registers around them: a registered seed ROM read, the seed
// register, two Newton steps of four 3-stage multipliers and one 2-stage subtractor
// each, the final 3-stage multiply by x and the output register.
// Reset is synchronous; busy is high while reset is high and the pipe is flushed.
// The receiver cannot stall, so the pipe never holds and results leave in order.
`default_nettype none

`include "table_seeded_float_rsqrt_unit_defines.svh"

module table_seeded_float_rsqrt_unit
   import trsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_x_bits,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result_bits
);

   localparam int LATENCY = 2 + 2 * (4 * FMUL_STAGES + FSUB_STAGES) + FMUL_STAGES + 1;

   localparam seed_rom_type SEED_ROM = build_seed_rom();

   logic accept;

   // Only reset holds off requests; the pipe advances every cycle.
   assign busy   = reset;
   assign accept = start & ~busy;

   //------------------------------------------------------------------------
   // Stage 1: registered seed ROM read, indexed by exponent lsb and mantissa top
   //------------------------------------------------------------------------
   logic       s1_valid_ff;
   logic       s1_op_ff;
   logic [31:0] s1_x_ff;
   logic [7:0] rom_q_ff;

   always_ff @(posedge clock) begin
      rom_q_ff <= SEED_ROM[req_x_bits[SEED_LSB + SEED_ADDR_W - 1:SEED_LSB]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff <= req_op;
      s1_x_ff  <= req_x_bits;
   end

   //------------------------------------------------------------------------
   // Stage 2: seed word. Exponent comes from the magic subtract (wraps mod 2^32),
   // masked to sign and exponent; mantissa top byte comes from the ROM.
   //------------------------------------------------------------------------
   logic [31:0] seed_in;
   logic        s2_valid_ff;
   side_type    s2_side_ff;

   assign seed_in = ((SEED_EXP_BASE - {2'd0, s1_x_ff[30:23], 22'd0}) & SEED_EXP_MASK)
                  | {9'd0, rom_q_ff, 15'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff <= '{op: s1_op_ff, x_bits: s1_x_ff, y_bits: seed_in};
   end

   //------------------------------------------------------------------------
   // Newton steps: y = ((3.0 - (y*y)*x) * y) * 0.5, twice.
   // Entry k of nv_* is the word entering step k; the last entry leaves step 2.
   //------------------------------------------------------------------------
   logic     nv_valid [3];
   side_type nv_side  [3];

   assign nv_valid[0] = s2_valid_ff;
   assign nv_side[0]  = s2_side_ff;

   for (genvar k = 0; k < 2; k++) begin : g_newton
      logic        m1_valid, m2_valid, m3_valid, m4_valid;
      logic [31:0] m1_z, m2_z, m3_z, m4_z;
      side_type    m1_side, m2_side, m3_side, m4_side;

      // y*y
      trsq_fmul u_sq (
         .clock    (clock),
         .reset    (reset),
         .in_valid (nv_valid[k]),
         .in_a     (nv_side[k].y_bits),
         .in_b     (nv_side[k].y_bits),
         .in_side  (nv_side[k]),
         .out_valid(m1_valid),
         .out_z    (m1_z),
         .out_side (m1_side)
      );

      // (y*y)*x
      trsq_fmul u_tx (
         .clock    (clock),
         .reset    (reset),
         .in_valid (m1_valid),
         .in_a     (m1_z),
         .in_b     (m1_side.x_bits),
         .in_side  (m1_side),
         .out_valid(m2_valid),
         .out_z    (m2_z),
         .out_side (m2_side)
      );

      // 3.0 - t, stage A: align and add or subtract magnitudes
      logic        sa_spec_in;
      logic [31:0] sa_specval_in;
      logic        sa_sign_in;
      logic [7:0]  sa_exp_in;
      logic [27:0] sa_sum_in;

      logic        sa_valid_ff;
      side_type    sa_side_ff;
      logic        sa_spec_ff;
      logic [31:0] sa_specval_ff;
      logic        sa_sign_ff;
      logic [7:0]  sa_exp_ff;
      logic [27:0] sa_sum_ff;

      always_comb begin
         logic [31:0] b_bits;
         logic [7:0]  ea, eb, eea, eeb, e_big, e_small, diff;
         logic [23:0] ma, mb, m_big, m_small;
         logic        s_big, s_small, swap;
         logic [4:0]  dcap;
         logic [53:0] wide;
         logic [26:0] hi, al, m_big27;
         b_bits  = m2_z ^ F32_SIGN_BIT;
         ea      = F32_THREE[30:23];
         eb      = b_bits[30:23];
         ma      = {ea != 8'd0, F32_THREE[22:0]};
         mb      = {eb != 8'd0, b_bits[22:0]};
         eea     = (ea == 8'd0) ? 8'd1 : ea;
         eeb     = (eb == 8'd0) ? 8'd1 : eb;
         swap    = {eeb, mb} > {eea, ma};
         e_big   = swap ? eeb : eea;
         e_small = swap ? eea : eeb;
         m_big   = swap ? mb : ma;
         m_small = swap ? ma : mb;
         s_big   = swap ? b_bits[31] : F32_THREE[31];
         s_small = swap ? F32_THREE[31] : b_bits[31];
         diff    = e_big - e_small;
         dcap    = (diff > 8'd27) ? 5'd27 : diff[4:0];
         wide    = {m_small, 3'd0, 27'd0} >> dcap;
         hi      = wide[53:27];
         al      = {hi[26:1], hi[0] | (|wide[26:0])};
         m_big27 = {m_big, 3'd0};
         if (s_big == s_small) begin
            sa_sum_in = {1'b0, m_big27} + {1'b0, al};
         end else begin
            sa_sum_in = {1'b0, m_big27} - {1'b0, al};
         end
         sa_sign_in = s_big;
         sa_exp_in  = e_big;
         // NaN t comes back quieted with its own sign; infinite t flips sign
         sa_spec_in    = 1'b1;
         sa_specval_in = m2_z | F32_QNAN_BIT;
         if ((m2_z[30:23] == 8'hff) && (m2_z[22:0] != 23'd0)) begin
            sa_specval_in = m2_z | F32_QNAN_BIT;
         end else if (m2_z[30:23] == 8'hff) begin
            sa_specval_in = b_bits;
         end else begin
            sa_spec_in = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sa_valid_ff <= 1'b0;
         end else begin
            sa_valid_ff <= m2_valid;
         end
      end

      always_ff @(posedge clock) begin
         sa_side_ff    <= m2_side;
         sa_spec_ff    <= sa_spec_in;
         sa_specval_ff <= sa_specval_in;
         sa_sign_ff    <= sa_sign_in;
         sa_exp_ff     <= sa_exp_in;
         sa_sum_ff     <= sa_sum_in;
      end

      // 3.0 - t, stage B: normalize, round, pack
      logic [31:0] sb_d_in;
      logic        sb_valid_ff;
      side_type    sb_side_ff;
      logic [31:0] sb_d_ff;

      always_comb begin
         logic [4:0]  lz;
         logic [8:0]  sh;
         logic [8:0]  e;
         logic [26:0] m;
         logic [7:0]  expf;
         logic        inc;
         logic [30:0] mag;
         lz = 5'd0;
         for (int i = 0; i < 27; i++) begin
            if (sa_sum_ff[i]) begin
               lz = 5'(26 - i);
            end
         end
         if (sa_sum_ff[27]) begin
            m  = {sa_sum_ff[27:2], sa_sum_ff[1] | sa_sum_ff[0]};
            e  = {1'b0, sa_exp_ff} + 9'd1;
            sh = 9'd0;
         end else begin
            sh = ({4'd0, lz} < {1'b0, sa_exp_ff}) ? {4'd0, lz}
                                                   : ({1'b0, sa_exp_ff} - 9'd1);
            m  = sa_sum_ff[26:0] << sh;
            e  = {1'b0, sa_exp_ff} - sh;
         end
         expf = m[26] ? e[7:0] : 8'd0;
         inc  = m[2] & (m[1] | m[0] | m[3]);
         mag  = {expf, m[25:3]} + {30'd0, inc};
         if (sa_spec_ff) begin
            sb_d_in = sa_specval_ff;
         end else if (sa_sum_ff == 28'd0) begin
            sb_d_in = 32'd0;
         end else if (e >= 9'd255) begin
            sb_d_in = {sa_sign_ff, 8'hff, 23'd0};
         end else begin
            sb_d_in = {sa_sign_ff, mag};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sb_valid_ff <= 1'b0;
         end else begin
            sb_valid_ff <= sa_valid_ff;
         end
      end

      always_ff @(posedge clock) begin
         sb_side_ff <= sa_side_ff;
         sb_d_ff    <= sb_d_in;
      end

      // d*y
      trsq_fmul u_dy (
         .clock    (clock),
         .reset    (reset),
         .in_valid (sb_valid_ff),
         .in_a     (sb_d_ff),
         .in_b     (sb_side_ff.y_bits),
         .in_side  (sb_side_ff),
         .out_valid(m3_valid),
         .out_z    (m3_z),
         .out_side (m3_side)
      );

      // p*0.5
      trsq_fmul u_half (
         .clock    (clock),
         .reset    (reset),
         .in_valid (m3_valid),
         .in_a     (m3_z),
         .in_b     (F32_HALF),
         .in_side  (m3_side),
         .out_valid(m4_valid),
         .out_z    (m4_z),
         .out_side (m4_side)
      );

      // advance: the refined estimate replaces y
      assign nv_valid[k + 1] = m4_valid;
      assign nv_side[k + 1]  = '{op: m4_side.op, x_bits: m4_side.x_bits, y_bits: m4_z};
   end

   //------------------------------------------------------------------------
   // Final multiply y*x, used for sqrt; rsqrt drops it and keeps y.
   //------------------------------------------------------------------------
   logic        f_valid;
   logic [31:0] f_z;
   side_type    f_side;

   trsq_fmul u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_valid (nv_valid[2]),
      .in_a     (nv_side[2].y_bits),
      .in_b     (nv_side[2].x_bits),
      .in_side  (nv_side[2]),
      .out_valid(f_valid),
      .out_z    (f_z),
      .out_side (f_side)
   );

   // Output register: each result word shows for exactly one cycle.
   logic        rsp_strobe_ff;
   logic [31:0] rsp_result_bits_ff;
   logic [31:0] rsp_result_bits_in;

   assign rsp_result_bits_in = f_side.op ? f_z : f_side.y_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_bits_ff <= rsp_result_bits_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_bits = rsp_result_bits_ff;

   //------------------------------------------------------------------------
   // Checks
   //------------------------------------------------------------------------
   // every accepted word yields its result after the fixed pipe depth
   `TRSQ_ASSERT_IMP(a_result_follows, clock, reset, accept, ##LATENCY rsp_strobe, "result lost")
   // no result word without a request the pipe depth earlier
   `TRSQ_ASSERT_IMP(a_no_spurious, clock, reset, rsp_strobe, $past(accept, LATENCY), "spurious result")
   // a canonical quiet NaN passes through both steps and the final multiply
   `TRSQ_ASSERT_IMP(a_qnan_passes, clock, reset, accept && (req_x_bits == 32'h7fc0_0000), ##LATENCY (rsp_result_bits == 32'h7fc0_0000), "NaN not propagated")
   // the seed stage takes each word from the ROM read stage in the next cycle
   `TRSQ_ASSERT_NXT(a_seed_follows, clock, reset, s1_valid_ff, s2_valid_ff, "seed stage dropped a word")

endmodule

`default_nettype wire

### hw/rtl/trsq_fmul.sv
// Three-stage IEEE single multiplier, round to nearest even, side word passed along.
`default_nettype none

module trsq_fmul
   import trsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_a,
   input  logic [31:0] in_b,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] out_z,
   output side_type    out_side
);

   // stage 1: unpack, specials, mantissa product
   logic               spec1_in;
   logic [31:0]        specval1_in;
   logic               sign1_in;
   logic signed [10:0] exp1_in;
   logic [47:0]        prod1_in;

   logic               valid1_ff;
   side_type           side1_ff;
   logic               spec1_ff;
   logic [31:0]        specval1_ff;
   logic               sign1_ff;
   logic signed [10:0] exp1_ff;
   logic [47:0]        prod1_ff;

   always_comb begin
      logic [7:0]  ea, eb, eea, eeb;
      logic [22:0] fa, fb;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      ea     = in_a[30:23];
      eb     = in_b[30:23];
      fa     = in_a[22:0];
      fb     = in_b[22:0];
      a_nan  = (ea == 8'hff) && (fa != 23'd0);
      b_nan  = (eb == 8'hff) && (fb != 23'd0);
      a_inf  = (ea == 8'hff) && (fa == 23'd0);
      b_inf  = (eb == 8'hff) && (fb == 23'd0);
      a_zero = (ea == 8'd0) && (fa == 23'd0);
      b_zero = (eb == 8'd0) && (fb == 23'd0);
      eea    = (ea == 8'd0) ? 8'd1 : ea;
      eeb    = (eb == 8'd0) ? 8'd1 : eb;
      sign1_in    = in_a[31] ^ in_b[31];
      spec1_in    = 1'b1;
      specval1_in = {sign1_in, 31'd0};
      if (a_nan) begin
         specval1_in = in_a | F32_QNAN_BIT;
      end else if (b_nan) begin
         specval1_in = in_b | F32_QNAN_BIT;
      end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
         specval1_in = F32_DEFAULT_NAN;
      end else if (a_inf || b_inf) begin
         specval1_in = {sign1_in, 8'hff, 23'd0};
      end else if (a_zero || b_zero) begin
         specval1_in = {sign1_in, 31'd0};
      end else begin
         spec1_in = 1'b0;
      end
      exp1_in  = $signed({3'd0, eea}) + $signed({3'd0, eeb}) - 11'sd127;
      prod1_in = 48'({ea != 8'd0, fa}) * 48'({eb != 8'd0, fb});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff    <= in_side;
      spec1_ff    <= spec1_in;
      specval1_ff <= specval1_in;
      sign1_ff    <= sign1_in;
      exp1_ff     <= exp1_in;
      prod1_ff    <= prod1_in;
   end

   // stage 2: leading zero count, normalize
   logic [5:0]         lz2;
   logic signed [10:0] be2_in;
   logic [47:0]        norm2_in;

   logic               valid2_ff;
   side_type           side2_ff;
   logic               spec2_ff;
   logic [31:0]        specval2_ff;
   logic               sign2_ff;
   logic signed [10:0] be2_ff;
   logic [47:0]        norm2_ff;

   always_comb begin
      lz2 = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (prod1_ff[i]) begin
            lz2 = 6'(47 - i);
         end
      end
      norm2_in = prod1_ff << lz2;
      be2_in   = exp1_ff + 11'sd1 - $signed({5'd0, lz2});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      side2_ff    <= side1_ff;
      spec2_ff    <= spec1_ff;
      specval2_ff <= specval1_ff;
      sign2_ff    <= sign1_ff;
      be2_ff      <= be2_in;
      norm2_ff    <= norm2_in;
   end

   // stage 3: denormalize if needed, round, pack
   logic [31:0] z3_in;
   logic        valid3_ff;
   side_type    side3_ff;
   logic [31:0] z3_ff;

   always_comb begin
      logic signed [10:0] rs_full;
      logic [5:0]         rs;
      logic [7:0]         expf;
      logic [111:0]       wide;
      logic [23:0]        kept;
      logic               grd, sticky, inc;
      logic [30:0]        mag;
      rs_full = 11'sd1 - be2_ff;
      if (be2_ff >= 11'sd1) begin
         rs   = 6'd0;
         expf = be2_ff[7:0];
      end else begin
         rs   = (rs_full > 11'sd63) ? 6'd63 : rs_full[5:0];
         expf = 8'd0;
      end
      wide   = {norm2_ff, 64'd0} >> rs;
      kept   = wide[111:88];
      grd    = wide[87];
      sticky = |wide[86:0];
      inc    = grd & (sticky | kept[0]);
      mag    = {expf, kept[22:0]} + {30'd0, inc};
      if (spec2_ff) begin
         z3_in = specval2_ff;
      end else if (be2_ff >= 11'sd255) begin
         z3_in = {sign2_ff, 8'hff, 23'd0};
      end else begin
         z3_in = {sign2_ff, mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side3_ff <= side2_ff;
      z3_ff    <= z3_in;
   end

   assign out_valid = valid3_ff;
   assign out_z     = z3_ff;
   assign out_side  = side3_ff;

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the table-seeded single-precision rsqrt / sqrt unit.
`timescale 1ns / 100ps

module tb_top;
   import trsq_pkg::*;

   localparam int PIPE_DEPTH   = 34;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_WORDS = 555;

   localparam logic OP_RSQRT = 1'b0;
   localparam logic OP_SQRT  = 1'b1;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_op;
   logic [31:0] req_x_bits;
   logic        rsp_strobe;
   logic [31:0] rsp_result_bits;

   logic [7:0]  seed_bytes [SEED_ENTRIES];
   logic [31:0] expected_results [$];
   int          error_count;
   int          quiet_cycles;
   bit          gaps_on;

   table_seeded_float_rsqrt_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_x_bits      (req_x_bits),
      .rsp_strobe      (rsp_strobe),
      .rsp_result_bits (rsp_result_bits)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ---------------------------------------------------------------------
   // Seed table: byte of rounded 1/sqrt(f), f = n / 2^s, taken at bits 22..15.
   // ---------------------------------------------------------------------
   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   function automatic logic [7:0] seed_byte(input int unsigned idx);
      longint unsigned num;
      longint unsigned q;
      longint unsigned sig;
      int unsigned     scale;
      logic [31:0]     ex;
      logic [31:0]     pattern;
      num   = 512 + (idx & 511);
      scale = ((idx & 512) != 0) ? 9 : 10;
      q     = isqrt64((64'd1 << (scale + 52)) / num);
      if (q >= (64'd1 << 26)) begin
         ex  = 127;
         sig = (q + 4) >> 3;
      end else begin
         ex  = 126;
         sig = (q + 2) >> 2;
      end
      if (sig >= (64'd1 << 24)) begin
         ex  = ex + 1;
         sig = sig >> 1;
      end
      pattern = (ex << 23) | {9'd0, sig[22:0]};
      pattern = (pattern + 32'h2000) >> 15;
      return pattern[7:0];
   endfunction

   // ---------------------------------------------------------------------
   // Single-precision arithmetic, round to nearest even, full subnormals.
   // ---------------------------------------------------------------------
   function automatic bit f32_is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] != 0);
   endfunction

   function automatic bit f32_is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hff) && (a[22:0] == 0);
   endfunction

   // Round the exact value s * mant * 2^exp2 (lsb may carry sticky) to single.
   function automatic logic [31:0] f32_round(input bit s, input int exp2,
                                             input logic [63:0] mant);
      int          msb;
      int          sh;
      int          ex;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      if (mant == 0) return {s, 31'd0};
      msb = 63;
      while (!mant[msb]) msb--;
      sh = msb - 23;
      if (sh < -149 - exp2) sh = -149 - exp2;
      if (sh > 60) return {s, 31'd0};
      if (sh > 0) begin
         keep = mant >> sh;
         rem  = mant & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && keep[0])) keep = keep + 1;
      end else begin
         keep = mant << (-sh);
      end
      ex = exp2 + sh;
      if (keep[24]) begin
         keep = keep >> 1;
         ex   = ex + 1;
      end
      if (!keep[23]) return {s, 8'd0, keep[22:0]};
      ex = ex + 150;
      if (ex >= 255) return {s, 8'hff, 23'd0};
      return {s, ex[7:0], keep[22:0]};
   endfunction

   // Significand and exponent such that |a| = mant * 2^exp2.
   function automatic void f32_split(input logic [31:0] a, output logic [63:0] mant,
                                     output int exp2);
      if (a[30:23] == 0) begin
         mant = {41'd0, a[22:0]};
         exp2 = 1 - 150;
      end else begin
         mant = {40'd0, 1'b1, a[22:0]};
         exp2 = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      int          ea;
      int          eb;
      bit          s;
      s = a[31] ^ b[31];
      if (f32_is_nan(a)) return a | F32_QNAN_BIT;
      if (f32_is_nan(b)) return b | F32_QNAN_BIT;
      if (f32_is_inf(a) || f32_is_inf(b)) begin
         // infinity times zero is invalid
         if (a[30:0] == 0 || b[30:0] == 0) return F32_DEFAULT_NAN;
         return {s, 8'hff, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      f32_split(a, ma, ea);
      f32_split(b, mb, eb);
      return f32_round(s, ea + eb, ma * mb);
   endfunction

   function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] big;
      logic [63:0] lil;
      logic [63:0] tmpm;
      logic [63:0] total;
      int          ea;
      int          eb;
      int          tmpe;
      int          base;
      int          rsh;
      bit          sa;
      bit          sb;
      bit          tmps;
      bit          s;
      if (f32_is_nan(a)) return a | F32_QNAN_BIT;
      if (f32_is_nan(b)) return b | F32_QNAN_BIT;
      b = b ^ F32_SIGN_BIT;
      if (f32_is_inf(a) && f32_is_inf(b)) begin
         if (a[31] != b[31]) return F32_DEFAULT_NAN;
         return a;
      end
      if (f32_is_inf(a)) return a;
      if (f32_is_inf(b)) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      f32_split(a, ma, ea);
      f32_split(b, mb, eb);
      sa = a[31];
      sb = b[31];
      if (ea < eb) begin
         tmpm = ma; ma = mb; mb = tmpm;
         tmpe = ea; ea = eb; eb = tmpe;
         tmps = sa; sa = sb; sb = tmps;
      end
      // keep 26 spare bits under the larger operand; fold the rest into a sticky
      base = (ea - eb > 26) ? ea - 26 : eb;
      big  = ma << (ea - base);
      rsh  = base - eb;
      if (rsh >= 64) lil = (mb != 0);
      else if (rsh > 0) lil = (mb >> rsh) | ((mb & ((64'd1 << rsh) - 1)) != 0);
      else lil = mb;
      if (sa == sb) begin
         total = big + lil;
         s     = sa;
      end else if (big >= lil) begin
         total = big - lil;
         s     = sa;
      end else begin
         total = lil - big;
         s     = sb;
      end
      if (total == 0) return 32'd0;
      return f32_round(s, base, total);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: seed, two Newton steps, optional multiply by x.
   // ---------------------------------------------------------------------
   function automatic logic [31:0] newton_refine(input logic [31:0] y, input logic [31:0] x);
      logic [31:0] t;
      t = f32_mul(f32_mul(y, y), x);
      t = f32_sub(F32_THREE, t);
      return f32_mul(f32_mul(t, y), F32_HALF);
   endfunction

   function automatic logic [31:0] rsqrt_predict(input logic op, input logic [31:0] x);
      logic [31:0] ex;
      logic [31:0] y;
      ex = {24'd0, x[30:23]};
      y  = ((SEED_EXP_BASE - (ex << 22)) & SEED_EXP_MASK)
         | ({24'd0, seed_bytes[x[23:14]]} << 15);
      y  = newton_refine(y, x);
      y  = newton_refine(y, x);
      if (op == OP_SQRT) y = f32_mul(y, x);
      return y;
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Drive one word and hold it until the unit takes it.
   task automatic send_word(input logic op, input logic [31:0] x);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      start      <= 1'b1;
      req_op     <= op;
      req_x_bits <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_results.push_back(rsqrt_predict(op, x));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Random operand biased toward interesting regions of the format.
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 7))
         0, 1:    v[31:23] = {1'b0, 8'($urandom_range(100, 154))};  // near one
         2:       v[30:23] = 8'd0;                                   // subnormal
         3:       v[30:23] = 8'($urandom_range(0, 1) ? 8'hff : 8'hfe);
         4:       v[30:23] = 8'($urandom_range(1, 3));
         default: ;
      endcase
      return v;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_special_values();
      logic [31:0] corner [13];
      corner = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'h7f80_0001, 32'hffff_ffff, 32'h0000_0001,
                 32'h007f_ffff, 32'h7f7f_ffff, 32'h3f80_0000, 32'h4080_0000,
                 32'hbf80_0000};
      foreach (corner[i]) begin
         send_word(OP_RSQRT, corner[i]);
         send_word(OP_SQRT, corner[i]);
      end
   endtask

   // Visit every 37th seed-table index, then the forced entry.
   task automatic test_seed_table();
      for (int i = 0; i < SEED_ENTRIES; i += 37) begin
         send_word(1'($urandom_range(0, 1)), {1'b0, 7'h3f, 10'(i), 14'($urandom())});
      end
      send_word(OP_RSQRT, 32'h3f80_0000);
   endtask

   // Pause the sender until the pipe is empty, then resume.
   task automatic test_drain_pause();
      repeat (20) send_word(1'($urandom_range(0, 1)), pick_operand());
      drain_results();
      repeat (20) send_word(1'($urandom_range(0, 1)), pick_operand());
   endtask

   task automatic test_random_stream();
      repeat (RANDOM_WORDS - 100) send_word(1'($urandom_range(0, 1)), pick_operand());
   endtask

   // Back-to-back words with no gaps to keep the pipe full.
   task automatic test_full_rate();
      gaps_on = 1'b0;
      repeat (100) send_word(1'($urandom_range(0, 1)), pick_operand());
      start <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result checker and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("rsp_result_bits: unexpected result %h", rsp_result_bits);
            error_count++;
         end else begin
            if (rsp_result_bits !== expected_results[0]) begin
               $error("rsp_result_bits: expected %h actual %h",
                      expected_results[0], rsp_result_bits);
               error_count++;
            end
            void'(expected_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      error_count  = 0;
      quiet_cycles = 0;
      gaps_on      = 1'b1;
      start        = 1'b0;
      req_op       = OP_RSQRT;
      req_x_bits   = 32'd0;
      reset        = 1'b1;
      for (int i = 0; i < SEED_ENTRIES; i++) seed_bytes[i] = seed_byte(i);
      seed_bytes[SEED_ENTRIES / 2] = 8'hff;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_special_values();
      test_seed_table();
      test_drain_pause();
      test_random_stream();
      test_full_rate();

      drain_results();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### table_seeded_float_rsqrt_unit.f
+incdir+hw/rtl
hw/rtl/trsq_pkg.sv
hw/rtl/trsq_fmul.sv
hw/rtl/table_seeded_float_rsqrt_unit.sv
dv/tb_top.sv
